[rtl/soil_moisture_average_calibrate_assert.svh]
// Assertion macros shared by the soil moisture averaging and calibration block.
`ifndef SOIL_MOISTURE_AVERAGE_CALIBRATE_ASSERT_SVH
`define SOIL_MOISTURE_AVERAGE_CALIBRATE_ASSERT_SVH

`ifndef SYNTHESIS
`define SMAC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define SMAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SMAC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SMAC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[rtl/smac_pkg.sv]
`timescale 1ns / 1ps

package smac_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int WIN_W      = 8;
    localparam int REQ_W      = 16;
    localparam int SUM_W      = SAMPLE_W + WIN_W;
    localparam int PCT_W      = 7;
    localparam int NUM_W      = 19;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
    localparam logic [STEP_W-1:0] AVG_STEPS      = 5'd12;
    localparam logic [STEP_W-1:0] AVG_LONG_STEPS = 5'd20;
    localparam logic [STEP_W-1:0] PCT_STEPS      = 5'd7;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_DRY    = 2'd1;
    localparam logic [1:0] MODE_WET    = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_REQUEST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_PRESET      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET_PRESET      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET_VALID    = 3'd6;

    typedef struct packed {
        logic                start;
        logic [STEP_W-1:0]   steps;
        logic [SAMPLE_W-1:0] num_hi;
        logic [SUM_W-1:0]    num_lo;
        logic [SAMPLE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/smac_div.sv]
`timescale 1ns / 1ps

module smac_div import smac_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   count_reg, count_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]    lo_reg, lo_next;
    logic [SAMPLE_W-1:0] quo_reg, quo_next;
    logic [SAMPLE_W-1:0] div_reg, div_next;
    logic [SAMPLE_W+1:0] trial;

    // One quotient bit per cycle: restoring subtraction of the divisor.
    assign trial = {1'b0, rem_reg, lo_reg[SUM_W-1]} - {2'b00, div_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            count_next = req.steps;
            rem_next   = req.num_hi;
            lo_next    = req.num_lo;
            quo_next   = '0;
            div_next   = req.divisor;
        end else if (busy_reg) begin
            lo_next    = {lo_reg[SUM_W-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (!trial[SAMPLE_W+1]) begin
                rem_next = trial[SAMPLE_W-1:0];
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[SAMPLE_W-2:0], lo_reg[SUM_W-1]};
                quo_next = {quo_reg[SAMPLE_W-2:0], 1'b0};
            end
            if (count_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/soil_moisture_average_calibrate.sv]
// Soil moisture averaging and two-point calibration.
// Samples arrive on the s_ stream, one 12-bit converter reading per transfer.
// They are summed over a window of window_samples readings (zero counts as one);
// a window that ends yields one result transfer on the m_ stream, other samples
// yield none. Configuration is written over the cfg_ channel, which is always ready;
// writing a preset register loads the working dry point, wet point or valid flag.
// A sample that does not end a window leaves the block ready for the next one. A
// window-ending sample is followed, in order, by a divider start and 12 steps of the
// shared serial divider forming the average, the capture check, the clamp, the multiply
// by 100, a second divider start and 7 percent steps, and the load of the output; only
// then is the next sample taken. When dry does not exceed wet the multiply and the
// percent steps are skipped. A window shortened below the samples already taken can
// need 20 average steps. The divider forms one quotient bit per cycle.
// The result is held in an output register; the next window may be summed while it
// waits, but a further result is not loaded until the receiver has taken the first, so a
// stalled receiver halts the block after at most one more window.
// Synchronous active-low reset clears the window sum and index, the calibration points,
// the valid flag and the last request id, and sets a window of one and a minimum span of 200.
`timescale 1ns / 1ps
`include "soil_moisture_average_calibrate_assert.svh"

module soil_moisture_average_calibrate import smac_pkg::*; #(
    parameter int MAX_WINDOW   = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [11:0] adc_sample
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [6:0] moisture_percent, [18:7] average_raw, [19] needs_calibration,
    // [21:20] capture_kind, [22] capture_applied, [23] capture_duplicate,
    // [24] capture_error
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(MAX_WINDOW);

    typedef enum logic [3:0] {
        S_IDLE, S_AVG_GO, S_AVG_WAIT, S_CAPT, S_CLAMP,
        S_MUL, S_PCT_GO, S_PCT_WAIT, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [WIN_W-1:0]    win_reg, win_next;
    logic [1:0]          mode_reg, mode_next;
    logic [REQ_W-1:0]    creq_reg, creq_next;
    logic [SAMPLE_W-1:0] mspan_reg, mspan_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [WIN_W-1:0]    idx_reg, idx_next;
    logic [SAMPLE_W-1:0] dry_reg, dry_next;
    logic [SAMPLE_W-1:0] wet_reg, wet_next;
    logic                calv_reg, calv_next;
    logic [REQ_W-1:0]    lreq_reg, lreq_next;
    logic [SUM_W-1:0]    tot_reg, tot_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [1:0]          kind_reg, kind_next;
    logic                app_reg, app_next;
    logic                dup_reg, dup_next;
    logic                err_reg, err_next;
    logic [SAMPLE_W-1:0] diff_reg, diff_next;
    logic [SAMPLE_W-1:0] span_reg, span_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [PCT_W-1:0]    pct_reg, pct_next;
    logic                mval_reg, mval_next;
    logic [M_TDATA_W-1:0] mdat_reg, mdat_next;

    logic [WIN_W-1:0]    win_len;
    logic [WIN_W-1:0]    idx_inc;
    logic [SAMPLE_W-1:0] sample;
    logic                capturing;
    logic [REQ_W-1:0]    req_id;
    logic [SAMPLE_W-1:0] new_dry, new_wet, clamped;
    logic [SAMPLE_W-1:0] new_span;
    logic                cap_ok;
    div_req_t            dreq;
    div_rsp_t            drsp;

    smac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_comb begin
        win_len = (win_reg == '0) ? WIN_W'(1) : win_reg;
        if (win_len > WIN_CAP) begin
            win_len = WIN_CAP;
        end
    end

    assign idx_inc   = idx_reg + 1'b1;
    assign sample    = s_tdata[SAMPLE_W-1:0];
    assign capturing = (mode_reg == MODE_DRY) || (mode_reg == MODE_WET);
    assign req_id    = creq_reg;
    assign new_dry   = (mode_reg == MODE_DRY) ? avg_reg : dry_reg;
    assign new_wet   = (mode_reg == MODE_WET) ? avg_reg : wet_reg;
    assign new_span  = new_dry - new_wet;
    assign cap_ok    = (new_dry > new_wet) && (new_span >= mspan_reg);

    always_comb begin
        if (avg_reg < wet_reg) begin
            clamped = wet_reg;
        end else if (avg_reg > dry_reg) begin
            clamped = dry_reg;
        end else begin
            clamped = avg_reg;
        end
    end

    always_comb begin
        dreq.start   = (state_reg == S_AVG_GO) || (state_reg == S_PCT_GO);
        dreq.steps   = AVG_STEPS;
        dreq.num_hi  = SAMPLE_W'(tot_reg[SUM_W-1:SAMPLE_W]);
        dreq.num_lo  = {tot_reg[SAMPLE_W-1:0], {(SUM_W-SAMPLE_W){1'b0}}};
        dreq.divisor = SAMPLE_W'(win_len);
        // A sum over more samples than the window length is divided from the top bit.
        if (tot_reg[SUM_W-1:SAMPLE_W] >= win_len) begin
            dreq.steps  = AVG_LONG_STEPS;
            dreq.num_hi = '0;
            dreq.num_lo = tot_reg;
        end
        if (state_reg == S_PCT_GO) begin
            dreq.steps   = PCT_STEPS;
            dreq.num_hi  = num_reg[NUM_W-1:PCT_W];
            dreq.num_lo  = {num_reg[PCT_W-1:0], {(SUM_W-PCT_W){1'b0}}};
            dreq.divisor = span_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        win_next   = win_reg;
        mode_next  = mode_reg;
        creq_next  = creq_reg;
        mspan_next = mspan_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        dry_next   = dry_reg;
        wet_next   = wet_reg;
        calv_next  = calv_reg;
        lreq_next  = lreq_reg;
        tot_next   = tot_reg;
        avg_next   = avg_reg;
        kind_next  = kind_reg;
        app_next   = app_reg;
        dup_next   = dup_reg;
        err_next   = err_reg;
        diff_next  = diff_reg;
        span_next  = span_reg;
        num_next   = num_reg;
        pct_next   = pct_reg;
        mval_next  = mval_reg;
        mdat_next  = mdat_reg;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if ((idx_inc == '0) || (idx_inc >= win_len)) begin
                        tot_next   = sum_reg + SUM_W'(sample);
                        sum_next   = '0;
                        idx_next   = '0;
                        state_next = S_AVG_GO;
                    end else begin
                        sum_next = sum_reg + SUM_W'(sample);
                        idx_next = idx_inc;
                    end
                end
            end
            S_AVG_GO: begin
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (drsp.done) begin
                    avg_next   = drsp.quotient;
                    state_next = S_CAPT;
                end
            end
            S_CAPT: begin
                kind_next = MODE_NORMAL;
                app_next  = 1'b0;
                dup_next  = 1'b0;
                err_next  = 1'b0;
                if (capturing) begin
                    kind_next = mode_reg;
                    lreq_next = req_id;
                    if ((req_id != '0) && (req_id == lreq_reg)) begin
                        dup_next = 1'b1;
                    end else if (cap_ok) begin
                        dry_next  = new_dry;
                        wet_next  = new_wet;
                        calv_next = 1'b1;
                        app_next  = 1'b1;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                if (dry_reg <= wet_reg) begin
                    pct_next   = '0;
                    state_next = S_DONE;
                end else begin
                    diff_next  = dry_reg - clamped;
                    span_next  = dry_reg - wet_reg;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                num_next   = NUM_W'(diff_reg) * NUM_W'(PCT_FULL);
                state_next = S_PCT_GO;
            end
            S_PCT_GO: begin
                state_next = S_PCT_WAIT;
            end
            S_PCT_WAIT: begin
                if (drsp.done) begin
                    pct_next   = drsp.quotient[PCT_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdat_next  = {7'b0, err_reg, dup_reg, app_reg, kind_reg, !calv_reg,
                                  avg_reg, pct_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WINDOW_SAMPLES:  win_next   = cfg_data[WIN_W-1:0];
                REG_CALIB_MODE:      mode_next  = cfg_data[1:0];
                REG_CAPTURE_REQUEST: creq_next  = cfg_data[REQ_W-1:0];
                REG_MIN_SPAN:        mspan_next = cfg_data[SAMPLE_W-1:0];
                REG_DRY_PRESET:      dry_next   = cfg_data[SAMPLE_W-1:0];
                REG_WET_PRESET:      wet_next   = cfg_data[SAMPLE_W-1:0];
                REG_PRESET_VALID:    calv_next  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            win_reg   <= WIN_W'(1);
            mode_reg  <= MODE_NORMAL;
            creq_reg  <= '0;
            mspan_reg <= SAMPLE_W'(200);
            sum_reg   <= '0;
            idx_reg   <= '0;
            dry_reg   <= '0;
            wet_reg   <= '0;
            calv_reg  <= 1'b0;
            lreq_reg  <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            win_reg   <= win_next;
            mode_reg  <= mode_next;
            creq_reg  <= creq_next;
            mspan_reg <= mspan_next;
            sum_reg   <= sum_next;
            idx_reg   <= idx_next;
            dry_reg   <= dry_next;
            wet_reg   <= wet_next;
            calv_reg  <= calv_next;
            lreq_reg  <= lreq_next;
            mval_reg  <= mval_next;
        end
        tot_reg  <= tot_next;
        avg_reg  <= avg_next;
        kind_reg <= kind_next;
        app_reg  <= app_next;
        dup_reg  <= dup_next;
        err_reg  <= err_next;
        diff_reg <= diff_next;
        span_reg <= span_next;
        num_reg  <= num_next;
        pct_reg  <= pct_next;
        mdat_reg <= mdat_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mval_reg;
    assign m_tdata   = mdat_reg;
    assign cfg_ready = 1'b1;

    `SMAC_ASSERT_IMPL(a_pct_range, aclk, aresetn, m_tvalid, m_tdata[6:0] <= PCT_FULL)
    `SMAC_ASSERT_IMPL(a_flags_exclusive, aclk, aresetn, m_tvalid, $onehot0(m_tdata[24:22]))
    `SMAC_ASSERT_IMPL(a_no_capture_no_flags, aclk, aresetn,
                      m_tvalid && (m_tdata[21:20] == MODE_NORMAL), m_tdata[24:22] == 3'b000)
    `SMAC_ASSERT_NEXT(a_capture_sets_valid, aclk, aresetn,
                      (state_reg == S_CAPT) && app_next, calv_reg && (state_reg == S_CLAMP))
    `SMAC_ASSERT_IMPL(a_div_start_idle, aclk, aresetn, dreq.start, !drsp.done)

endmodule
